// ===== design/multi_channel_range_filter_top_defines.svh =====
// assertion macros shared by the range filter rtl
`ifndef MULTI_CHANNEL_RANGE_FILTER_TOP_DEFINES_SVH
`define MULTI_CHANNEL_RANGE_FILTER_TOP_DEFINES_SVH

// concurrent check on the rising clock, quiet while reset is high
`define MCRF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("range filter check failed");

// same check with a caller supplied message string
`define MCRF_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`endif

// ===== design/mcrf_pkg.sv =====
package mcrf_pkg;

   // channel count default
   localparam int NUM_CHANNELS_DEF = 6;

   // field widths
   localparam int CH_W       = 3;
   localparam int MM_W       = 16;
   localparam int NOW_W      = 32;
   localparam int CM_W       = 10;
   localparam int CM_RAW_W   = 13;
   localparam int SMOOTH_W   = 18;
   localparam int FILL_W     = 2;
   localparam int ALPHA_W    = 9;
   localparam int SILENCE_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // packed stream widths
   localparam int REQ_FIELDS_W = CH_W + MM_W + 1 + NOW_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = CH_W + CM_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // reading limits
   localparam logic [MM_W-1:0] RAW_INVALID = 16'hFFFF;
   localparam logic [MM_W-1:0] FAR_MM      = 16'd8000;
   localparam logic [MM_W:0]   ROUND_MM    = 17'd5;

   // divide by ten as multiply by ceil(2^19 / 10), exact for inputs below 87381
   localparam logic [15:0] DIV10_RECIP = 16'd52429;
   localparam int          DIV10_SHIFT = 19;

   // alpha limits, q1.8
   localparam logic [ALPHA_W-1:0] ALPHA_MIN = 9'd1;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

   // history depth of the median
   localparam logic [FILL_W-1:0] FILL_FULL = 2'd3;

   // register reset values
   localparam logic [CM_W-1:0]      MAX_RANGE_RST = 10'd200;
   localparam logic [ALPHA_W-1:0]   ALPHA_RST     = 9'd77;
   localparam logic [SILENCE_W-1:0] SILENCE_RST   = 16'd500;

   typedef enum logic [1:0] {
      ACT_MEASURE = 2'd0,
      ACT_QUERY   = 2'd1,
      ACT_START   = 2'd2,
      ACT_DROP    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_VALID = 2'd0,
      ST_FAR   = 2'd1,
      ST_DEAD  = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_RANGE = 2'd0,
      CSR_ALPHA     = 2'd1,
      CSR_SILENCE   = 2'd2
   } csr_index_type;

   // one memory word per channel
   typedef struct packed {
      logic                ready;
      logic [SMOOTH_W-1:0] smooth;
      logic                smooth_valid;
      logic [CM_W-1:0]     hist_newest;
      logic [CM_W-1:0]     hist_middle;
      logic [CM_W-1:0]     hist_oldest;
      logic [FILL_W-1:0]   fill;
      logic                far;
      logic [NOW_W-1:0]    last_resp;
      logic [NOW_W-1:0]    last_good;
   } chan_state_type;

   // middle value of three
   function automatic logic [CM_W-1:0] median3(input logic [CM_W-1:0] a,
                                               input logic [CM_W-1:0] b,
                                               input logic [CM_W-1:0] c);
      logic [CM_W-1:0] lo;
      logic [CM_W-1:0] hi;
      logic [CM_W-1:0] hc;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      hc = (hi < c) ? hi : c;
      return (lo > hc) ? lo : hc;
   endfunction

endpackage

// ===== design/multi_channel_range_filter_top.sv =====
// Per-channel range conditioner for time-of-flight readings.
// Input stream (req_*): one transfer per item carries the action in req_tuser
// and channel, raw range in mm, timeout flag and millisecond time in req_tdata.
// Output stream (rsp_*): exactly one transfer per input item, in order, with
// the channel and rounded distance in rsp_tdata and the status in rsp_tuser.
// Configuration (csr_*): a write at any edge with csr_we high sets the register
// chosen by csr_index; indexes past the last register are ignored.
// Path: each item passes through the stage 1, stage 2 and output registers,
// in that order, before its result is presented on the output stream.
// Throughput: one item per cycle unless the output stalls; channel state is
// read at input transfer, updated in stage 1 and written back as the item
// leaves it; a last-write bypass covers an item that follows on that channel.
// Reset: csr registers return to their defaults, all channels read as cleared
// through per-entry valid bits, and the pipeline empties; req_tready is low
// while reset is high and items are taken in the first cycle after reset.
// Stall: with rsp_tready low the output register holds its result while the
// two stages behind it keep filling, so req_tready drops only once all three
// hold an item.
module multi_channel_range_filter_top #(
   parameter int NUM_CHANNELS = mcrf_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // channel[2:0], range_mm[18:3], timed_out[19], now_ms[51:20], zeros above
   input  logic [mcrf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // action[1:0]
   input  logic [1:0]                          req_tuser,
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_channel[2:0], distance_cm[12:3], zeros above
   output logic [mcrf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // range_status[1:0]
   output logic [1:0]                          rsp_tuser,
   // configuration writes
   input  logic                                csr_we,
   input  logic [mcrf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mcrf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mcrf_pkg::*;

`include "multi_channel_range_filter_top_defines.svh"

   localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // configuration registers
   logic [CM_W-1:0]      max_range_ff;
   logic [ALPHA_W-1:0]   alpha_ff;
   logic [SILENCE_W-1:0] silence_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= MAX_RANGE_RST;
         alpha_ff     <= ALPHA_RST;
         silence_ff   <= SILENCE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_RANGE: max_range_ff <= csr_wdata[CM_W-1:0];
            CSR_ALPHA:     alpha_ff     <= csr_wdata[ALPHA_W-1:0];
            CSR_SILENCE:   silence_ff   <= csr_wdata[SILENCE_W-1:0];
            default:       ;
         endcase
      end
   end

   // input field unpacking
   logic [CH_W-1:0]  req_ch;
   logic [MM_W-1:0]  req_mm;
   logic             req_tmo;
   logic [NOW_W-1:0] req_now;
   logic [ADDR_W-1:0] req_idx;
   logic             req_in_range;
   logic             req_xfer;
   logic [MM_W:0]    req_mm_rnd;
   logic [MM_W+16:0] req_cm_prod;

   assign req_ch       = req_tdata[CH_W-1:0];
   assign req_mm       = req_tdata[CH_W+MM_W-1:CH_W];
   assign req_tmo      = req_tdata[CH_W+MM_W];
   assign req_now      = req_tdata[CH_W+MM_W+1+NOW_W-1:CH_W+MM_W+1];
   assign req_idx      = ADDR_W'(req_ch);
   assign req_in_range = (32'(req_ch) < 32'(NUM_CHANNELS));
   assign req_xfer     = req_tvalid & req_tready;

   // mm to cm with round half up, by reciprocal multiply
   assign req_mm_rnd  = {1'b0, req_mm} + ROUND_MM;
   assign req_cm_prod = req_mm_rnd * DIV10_RECIP;

   // pipeline handshake
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, s2_adv, s2_free, s1_adv, s1_free;

   assign out_free   = ~out_valid_ff | rsp_tready;
   assign s2_adv     = s2_valid_ff & out_free;
   assign s2_free    = ~s2_valid_ff | s2_adv;
   assign s1_adv     = s1_valid_ff & s2_free;
   assign s1_free    = ~s1_valid_ff | s1_adv;
   assign req_tready = s1_free & ~reset;

   assign s1_valid_in  = req_xfer | (s1_valid_ff & ~s1_adv);
   assign s2_valid_in  = s1_adv | (s2_valid_ff & ~s2_adv);
   assign out_valid_in = s2_adv | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // channel state memory and per-entry written bits
   chan_state_type state_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] written_ff, written_in;

   // stage 1 item registers
   action_type        s1_action_ff;
   logic [CH_W-1:0]   s1_ch_ff;
   logic              s1_in_range_ff;
   logic [CM_RAW_W-1:0] s1_cm_ff;
   logic              s1_answered_ff;
   logic              s1_far_mm_ff;
   logic [NOW_W-1:0]  s1_now_ff;
   chan_state_type    rd_state_ff;
   logic              rd_written_ff;
   logic [ADDR_W-1:0] s1_idx;

   assign s1_idx = ADDR_W'(s1_ch_ff);

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_action_ff   <= action_type'(req_tuser);
         s1_ch_ff       <= req_ch;
         s1_in_range_ff <= req_in_range;
         s1_cm_ff       <= req_cm_prod[DIV10_SHIFT+CM_RAW_W-1:DIV10_SHIFT];
         s1_answered_ff <= ~req_tmo & (req_mm != RAW_INVALID);
         s1_far_mm_ff   <= (req_mm >= FAR_MM);
         s1_now_ff      <= req_now;
      end
   end

   // state read at input transfer
   always_ff @(posedge clock) begin
      if (req_xfer && req_in_range) begin
         rd_state_ff   <= state_mem[req_idx];
         rd_written_ff <= written_ff[req_idx];
      end
   end

   // last write bypass
   logic              lw_valid_ff;
   logic [ADDR_W-1:0] lw_idx_ff;
   chan_state_type    lw_state_ff;
   chan_state_type    s1_cur;
   chan_state_type    s1_nxt;
   logic              s1_wr;

   assign s1_wr = s1_adv & s1_in_range_ff;

   always_comb begin
      if (lw_valid_ff && (lw_idx_ff == s1_idx)) begin
         s1_cur = lw_state_ff;
      end else if (rd_written_ff) begin
         s1_cur = rd_state_ff;
      end else begin
         s1_cur = '0;
      end
   end

   // reading path: far test, median and exponential average
   logic [CM_W-1:0]      cm10;
   logic                 far_hit;
   logic [FILL_W-1:0]    fill_up;
   logic [CM_W-1:0]      med;
   logic [ALPHA_W-1:0]   alpha_eff;
   logic [SMOOTH_W-1:0]  med_q8;
   logic signed [SMOOTH_W:0]   ema_diff;
   logic signed [SMOOTH_W+ALPHA_W+1:0] ema_prod;
   logic [SMOOTH_W+11:0] ema_acc;

   assign cm10    = s1_cm_ff[CM_W-1:0];
   assign far_hit = s1_far_mm_ff | (s1_cm_ff > CM_RAW_W'(max_range_ff));
   assign fill_up = (s1_cur.fill < FILL_FULL) ? s1_cur.fill + 2'd1 : FILL_FULL;
   assign med     = (fill_up < FILL_FULL) ? cm10
                  : median3(cm10, s1_cur.hist_newest, s1_cur.hist_middle);

   always_comb begin
      if (alpha_ff == '0) begin
         alpha_eff = ALPHA_MIN;
      end else if (alpha_ff > ALPHA_ONE) begin
         alpha_eff = ALPHA_ONE;
      end else begin
         alpha_eff = alpha_ff;
      end
   end

   // (256-a)*s + a*m is computed as 256*s + a*(m - s)
   assign med_q8   = {med, 8'h00};
   assign ema_diff = $signed({1'b0, med_q8}) - $signed({1'b0, s1_cur.smooth});
   assign ema_prod = $signed({1'b0, alpha_eff}) * ema_diff;
   assign ema_acc  = {4'b0000, s1_cur.smooth, 8'h00}
                   + {ema_prod[SMOOTH_W+ALPHA_W+1], ema_prod}
                   + 30'd128;

   // next state of the channel
   always_comb begin
      s1_nxt = s1_cur;
      unique case (s1_action_ff)
         ACT_MEASURE: begin
            if (s1_cur.ready && s1_answered_ff) begin
               s1_nxt.last_resp = s1_now_ff;
               if (far_hit) begin
                  s1_nxt.far  = 1'b1;
                  s1_nxt.fill = '0;
               end else begin
                  s1_nxt.far         = 1'b0;
                  s1_nxt.hist_oldest = s1_cur.hist_middle;
                  s1_nxt.hist_middle = s1_cur.hist_newest;
                  s1_nxt.hist_newest = cm10;
                  s1_nxt.fill        = fill_up;
                  s1_nxt.smooth_valid = 1'b1;
                  s1_nxt.smooth      = s1_cur.smooth_valid ?
                                       ema_acc[SMOOTH_W+7:8] : med_q8;
                  s1_nxt.last_good   = s1_now_ff;
               end
            end
         end
         ACT_QUERY: ;
         ACT_START: begin
            s1_nxt           = '0;
            s1_nxt.last_resp = s1_now_ff;
            s1_nxt.ready     = 1'b1;
         end
         ACT_DROP: begin
            s1_nxt.ready = 1'b0;
         end
      endcase
   end

   // write back
   always_ff @(posedge clock) begin
      if (s1_wr) begin
         state_mem[s1_idx] <= s1_nxt;
      end
   end

   always_comb begin
      written_in = written_ff;
      if (s1_wr) begin
         written_in[s1_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff  <= '0;
         lw_valid_ff <= 1'b0;
      end else begin
         written_ff  <= written_in;
         lw_valid_ff <= lw_valid_ff | s1_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_wr) begin
         lw_idx_ff   <= s1_idx;
         lw_state_ff <= s1_nxt;
      end
   end

   // stage 2 registers
   logic [CH_W-1:0]  s2_ch_ff;
   logic             s2_in_range_ff;
   logic [NOW_W-1:0] s2_now_ff;
   chan_state_type   s2_state_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_ch_ff       <= s1_ch_ff;
         s2_in_range_ff <= s1_in_range_ff;
         s2_now_ff      <= s1_now_ff;
         s2_state_ff    <= s1_nxt;
      end
   end

   // liveness and status
   logic [NOW_W-1:0]    since_resp;
   logic [NOW_W-1:0]    since_good;
   logic                alive;
   logic                stale;
   logic [SMOOTH_W:0]   dist_rnd;
   status_type          status_in;
   logic [CM_W-1:0]     dist_in;

   assign since_resp = s2_now_ff - s2_state_ff.last_resp;
   assign since_good = s2_now_ff - s2_state_ff.last_good;
   assign alive      = s2_in_range_ff & s2_state_ff.ready
                     & (s2_state_ff.last_resp != '0)
                     & (since_resp <= NOW_W'(silence_ff));
   assign stale      = s2_state_ff.far | ~s2_state_ff.smooth_valid
                     | (since_good > NOW_W'(silence_ff));
   assign dist_rnd   = {1'b0, s2_state_ff.smooth} + 19'd128;

   always_comb begin
      status_in = ST_DEAD;
      dist_in   = '0;
      if (alive) begin
         if (stale) begin
            status_in = ST_FAR;
         end else begin
            status_in = ST_VALID;
            dist_in   = dist_rnd[SMOOTH_W-1:8];
         end
      end
   end

   // output register
   logic [CH_W-1:0] out_ch_ff;
   status_type      out_status_ff;
   logic [CM_W-1:0] out_dist_ff;

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         out_ch_ff     <= s2_ch_ff;
         out_status_ff <= status_in;
         out_dist_ff   <= dist_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_dist_ff, out_ch_ff});
   assign rsp_tuser  = out_status_ff;

   // checks
   `MCRF_ASSERT_MSG(a_bad_channel_dead, clock, reset,
      out_valid_ff && (32'(out_ch_ff) >= 32'(NUM_CHANNELS)) |-> out_status_ff == ST_DEAD,
      "unknown channel not reported dead")
   `MCRF_ASSERT_MSG(a_dist_only_valid, clock, reset,
      out_valid_ff && (out_status_ff != ST_VALID) |-> out_dist_ff == '0,
      "distance given without valid status")
   `MCRF_ASSERT(a_write_marks_entry, clock, reset,
      s1_wr |=> written_ff[$past(s1_idx)] && lw_valid_ff && (lw_idx_ff == $past(s1_idx)))
   `MCRF_ASSERT(a_stage2_holds, clock, reset,
      s2_valid_ff && !out_free |=> s2_valid_ff && $stable(s2_ch_ff))

endmodule
